// File: rtl/core/dgsp_pkg.sv
// Package for the dense graph shortest path core: sizes, command codes,
// state encoding and the per-cell control struct. No dependencies.
package dgsp_pkg;
    localparam int MaxNodes   = 16;
    localparam int WeightBits = 16;
    localparam int IdxBits    = 4;
    localparam int DistBits   = 20;
    localparam int CountBits  = 5;
    localparam logic [DistBits-1:0] Unreach = 20'hFFFFF;
    localparam logic [DistBits-1:0] UnreachM1 = 20'hFFFFE;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SELECT,
        ST_RELAX,
        ST_EMIT,
        ST_BAD
    } state_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic                 init;     // load distances for a new run
        logic [IdxBits-1:0]   src;      // source vertex of the run
        logic                 relax;    // apply relaxation from u
        logic [IdxBits-1:0]   u;        // vertex being settled
        logic [DistBits-1:0]  du;       // its distance
        logic                 shift;    // shift distances toward output
    } cell_ctl_t;
endpackage

// File: rtl/core/dgsp_cell.sv
// One vertex cell: holds the vertex distance and visited flag, relaxes
// against the settled vertex and passes its distance down the chain.
// Depends on dgsp_pkg.
module dgsp_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dgsp_pkg::IdxBits-1:0]  my_idx,
    input  logic                          in_use,
    input  dgsp_pkg::cell_ctl_t           ctl,
    input  logic [dgsp_pkg::WeightBits-1:0] w_uv,
    input  logic [dgsp_pkg::DistBits-1:0] shift_in,
    output logic [dgsp_pkg::DistBits-1:0] dist_out,
    output logic                          visited
);
    import dgsp_pkg::*;

    logic [DistBits-1:0] dist_reg, dist_next;
    logic                vis_reg, vis_next;
    logic [DistBits:0]   sum;
    logic [DistBits-1:0] cand;

    assign sum  = {1'b0, ctl.du} + {{(DistBits+1-WeightBits){1'b0}}, w_uv};
    assign cand = (sum >= {1'b0, Unreach}) ? UnreachM1 : sum[DistBits-1:0];

    // Relax, init or shift
    always_comb begin
        dist_next = dist_reg;
        vis_next  = vis_reg;
        if (ctl.init) begin
            dist_next = (my_idx == ctl.src) ? '0 : Unreach;
            vis_next  = ~in_use;
        end else if (ctl.relax) begin
            if (my_idx == ctl.u) begin
                vis_next = 1'b1;
            end else if (!vis_reg && w_uv != '0 && ctl.du != Unreach
                         && dist_reg > cand) begin
                dist_next = cand;
            end
        end else if (ctl.shift) begin
            dist_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_reg <= 1'b1;
        end else begin
            vis_reg <= vis_next;
        end
        dist_reg <= dist_next;
    end

    assign dist_out = dist_reg;
    assign visited  = vis_reg;
endmodule

// File: rtl/core/dgsp_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module dgsp_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/dense_graph_shortest_paths_core.sv
// Top level of the shortest path core: command decode, weight matrix rows,
// sequencer, chain of vertex cells and result register.
// Depends on dgsp_pkg, dgsp_ram, dgsp_cell.
//
// channel   dir  handshake               payload
// s_        in   s_tvalid/s_tready       cmd (tuser), vertex_a, vertex_b, weight
// m_        out  m_tvalid/m_tready       vertex, distance, reachable, bad_source, last
// cfg_      in   cfg_valid/cfg_ready     node_count
//
// A write command hits both matrix copies in the same cycle.
// A run is an init step, one settle step per vertex, then the output shift,
// which waits on m_tready; each settle step is a cell-chain scan, a row read
// from the matrix RAM, and a relax. Reset leaves the matrix all zero via a row
// clearing pass (one row of every cell bank per cycle); clear commands also sweep.
// m_tready low holds the chain; s_tready is low during runs and sweeps.
module dense_graph_shortest_paths_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // vertex_a[3:0], vertex_b[7:4], weight[23:8]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // vertex[3:0], distance[23:4]
    output logic [1:0]  m_tuser,   // reachable[0], bad_source[1]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import dgsp_pkg::*;

    // Input fields
    cmd_t                 in_cmd;
    logic [IdxBits-1:0]   in_a, in_b;
    logic [WeightBits-1:0] in_w;
    assign in_cmd = cmd_t'(s_tuser);
    assign in_a   = s_tdata[3:0];
    assign in_b   = s_tdata[7:4];
    assign in_w   = s_tdata[23:8];

    // Registers
    state_t               state_reg, state_next;
    logic [CountBits-1:0] ncount_reg;
    logic [IdxBits-1:0]   n_eff_m1_reg, n_eff_m1_next;
    logic [IdxBits-1:0]   src_reg, src_next;
    logic [CountBits-1:0] step_reg, step_next;
    logic [IdxBits-1:0]   u_reg, u_next;
    logic [DistBits-1:0]  du_reg, du_next;
    logic [IdxBits-1:0]   clr_reg, clr_next;
    logic                 clearing_reg, clearing_next;
    logic                 rd_wait_reg, rd_wait_next;
    logic [IdxBits-1:0]   ocnt_reg, ocnt_next;

    // Output register
    logic                 ov_reg, ov_next;
    logic [IdxBits-1:0]   ovtx_reg, ovtx_next;
    logic [DistBits-1:0]  odist_reg, odist_next;
    logic                 obad_reg, obad_next, olast_reg, olast_next;

    // Cell chain signals
    cell_ctl_t            ctl;
    logic [DistBits-1:0]  cell_dist [MaxNodes];
    logic                 vis  [MaxNodes];
    logic [WeightBits-1:0] wrow [MaxNodes];

    // Weight matrix: one bank per column v, indexed by row u. Holds both
    // (a,b) and (b,a) copies; a write stores into column b row a and column a
    // row b in the same cycle (two banks), or one bank on the diagonal.
    logic                 bank_we [MaxNodes];
    logic [IdxBits-1:0]   bank_wa [MaxNodes];
    logic [WeightBits-1:0] bank_wd;
    logic                 wr_go;

    assign bank_wd = clearing_reg ? '0 : in_w;

    genvar g;
    generate
        for (g = 0; g < MaxNodes; g++) begin : g_bank
            always_comb begin
                bank_we[g] = 1'b0;
                bank_wa[g] = clr_reg;
                if (clearing_reg) begin
                    bank_we[g] = 1'b1;
                end else if (wr_go) begin
                    if (in_b == IdxBits'(g)) begin
                        bank_we[g] = 1'b1;
                        bank_wa[g] = in_a;
                    end else if (in_a == IdxBits'(g)) begin
                        bank_we[g] = 1'b1;
                        bank_wa[g] = in_b;
                    end
                end
            end
            dgsp_ram #(.Width(WeightBits), .Depth(MaxNodes)) u_bank (
                .aclk  (aclk),
                .we    (bank_we[g]),
                .waddr (bank_wa[g]),
                .wdata (bank_wd),
                .raddr (u_reg),
                .rdata (wrow[g])
            );
            dgsp_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .my_idx   (IdxBits'(g)),
                .in_use   (IdxBits'(g) <= n_eff_m1_reg),
                .ctl      (ctl),
                .w_uv     (wrow[g]),
                .shift_in ((g == MaxNodes-1) ? Unreach : cell_dist[(g+1) % MaxNodes]),
                .dist_out (cell_dist[g]),
                .visited  (vis[g])
            );
        end
    endgenerate

    // Minimum search as a compare tree, ties toward the highest index.
    // Node k merges 2k (lower indices) and 2k+1 (higher indices).
    logic                tr_ok  [2*MaxNodes];
    logic [DistBits-1:0] tr_d   [2*MaxNodes];
    logic [IdxBits-1:0]  tr_idx [2*MaxNodes];
    logic [IdxBits-1:0]  min_idx;
    logic [DistBits-1:0] min_d;
    always_comb begin
        tr_ok[0]  = 1'b0;
        tr_d[0]   = Unreach;
        tr_idx[0] = '0;
        for (int i = 0; i < MaxNodes; i++) begin
            tr_ok[MaxNodes+i]  = !vis[i];
            tr_d[MaxNodes+i]   = cell_dist[i];
            tr_idx[MaxNodes+i] = IdxBits'(i);
        end
        for (int k = MaxNodes-1; k >= 1; k--) begin
            if (tr_ok[2*k+1] && (!tr_ok[2*k] || tr_d[2*k+1] <= tr_d[2*k])) begin
                tr_ok[k]  = 1'b1;
                tr_d[k]   = tr_d[2*k+1];
                tr_idx[k] = tr_idx[2*k+1];
            end else begin
                tr_ok[k]  = tr_ok[2*k];
                tr_d[k]   = tr_d[2*k];
                tr_idx[k] = tr_idx[2*k];
            end
        end
        min_idx = tr_ok[1] ? tr_idx[1] : '0;
        min_d   = tr_ok[1] ? tr_d[1] : Unreach;
    end

    // Effective node count
    logic [CountBits-1:0] n_eff;
    assign n_eff = (ncount_reg > CountBits'(MaxNodes)) ? CountBits'(MaxNodes) : ncount_reg;

    logic out_free;
    assign out_free = !ov_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE) && !clearing_reg && out_free;
    assign cfg_ready = 1'b1;
    assign wr_go     = s_tvalid && s_tready && in_cmd == CMD_WRITE;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        n_eff_m1_next = n_eff_m1_reg;
        src_next      = src_reg;
        step_next     = step_reg;
        u_next        = u_reg;
        du_next       = du_reg;
        clr_next      = clr_reg;
        clearing_next = clearing_reg;
        rd_wait_next  = rd_wait_reg;
        ocnt_next     = ocnt_reg;
        ov_next       = ov_reg && !m_tready;
        ovtx_next     = ovtx_reg;
        odist_next    = odist_reg;
        obad_next     = obad_reg;
        olast_next    = olast_reg;
        ctl           = '0;
        ctl.src       = src_reg;
        ctl.u         = u_reg;
        ctl.du        = du_reg;

        if (clearing_reg) begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == IdxBits'(MaxNodes-1)) clearing_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (in_cmd == CMD_CLEAR) begin
                        clearing_next = 1'b1;
                        clr_next      = '0;
                    end else if (in_cmd == CMD_RUN) begin
                        src_next = in_a;
                        if ({1'b0, in_a} >= n_eff) begin
                            state_next = ST_BAD;
                        end else begin
                            n_eff_m1_next = IdxBits'(n_eff - 1'b1);
                            state_next    = ST_INIT;
                        end
                    end
                end
            end
            ST_BAD: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    ovtx_next  = src_reg;
                    odist_next = Unreach;
                    obad_next  = 1'b1;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INIT: begin
                ctl.init   = 1'b1;
                step_next  = '0;
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                u_next       = min_idx;
                du_next      = min_d;
                rd_wait_next = 1'b1;
                state_next   = ST_RELAX;
            end
            ST_RELAX: begin
                if (rd_wait_reg) begin
                    rd_wait_next = 1'b0;
                end else begin
                    ctl.relax = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (step_reg == {1'b0, n_eff_m1_reg}) begin
                        ocnt_next  = '0;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SELECT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    ovtx_next  = ocnt_reg;
                    odist_next = cell_dist[0];
                    obad_next  = 1'b0;
                    olast_next = (ocnt_reg == n_eff_m1_reg);
                    ctl.shift  = 1'b1;
                    ocnt_next  = ocnt_reg + 1'b1;
                    if (ocnt_reg == n_eff_m1_reg) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ncount_reg   <= CountBits'(MaxNodes);
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
            ov_reg       <= 1'b0;
            rd_wait_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_reg      <= clr_next;
            ov_reg       <= ov_next;
            rd_wait_reg  <= rd_wait_next;
            if (cfg_valid && cfg_ready) ncount_reg <= cfg_data;
        end
        n_eff_m1_reg <= n_eff_m1_next;
        src_reg      <= src_next;
        step_reg     <= step_next;
        u_reg        <= u_next;
        du_reg       <= du_next;
        ocnt_reg     <= ocnt_next;
        ovtx_reg     <= ovtx_next;
        odist_reg    <= odist_next;
        obad_reg     <= obad_next;
        olast_reg    <= olast_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {odist_reg, ovtx_reg};
    assign m_tuser  = {obad_reg, (odist_reg != Unreach)};
    assign m_tlast  = olast_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && obad_reg) |-> olast_reg) else $error("bad result not last");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(ov_reg) && !$past(m_tready)) |-> ($stable(odist_reg) && ov_reg))
        else $error("result changed under stall");
`endif
endmodule

// File: sim/tb_top.sv
// Testbench for dense_graph_shortest_paths_core: drives commands, predicts run results
// with its own adjacency-matrix shortest path search, and checks every result transaction.
// Depends on dgsp_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dgsp_pkg::*;

    typedef struct packed {
        logic [IdxBits-1:0]  vertex;
        logic [DistBits-1:0] distance;
        logic                reachable;
        logic                bad_source;
        logic                last;
    } path_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    // Predictor state
    logic [WeightBits-1:0] edge_weight [MaxNodes][MaxNodes];
    logic [CountBits-1:0]  active_nodes;
    path_result_t          expected_paths[$];

    int  mismatch_count;
    bit  stall_long;
    int  gap_level;     // 0 none, 1 normal

    dense_graph_shortest_paths_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #60ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Dijkstra over the predictor matrix; ties go to the highest index.
    function automatic void predict_paths(logic [IdxBits-1:0] src);
        int unsigned n;
        int unsigned path_len[MaxNodes];
        bit          done[MaxNodes];
        int unsigned best;
        int unsigned u;
        int unsigned sum;
        path_result_t r;
        n = (active_nodes > MaxNodes) ? MaxNodes : active_nodes;
        if (src >= n) begin
            r.vertex = src;
            r.distance = Unreach;
            r.reachable = 1'b0;
            r.bad_source = 1'b1;
            r.last = 1'b1;
            expected_paths.push_back(r);
            return;
        end
        for (int i = 0; i < n; i++) begin
            path_len[i] = Unreach;
            done[i] = 1'b0;
        end
        path_len[src] = 0;
        for (int step = 0; step < n; step++) begin
            best = Unreach;
            u = 0;
            for (int v = 0; v < n; v++) begin
                if (!done[v] && path_len[v] <= best) begin
                    best = path_len[v];
                    u = v;
                end
            end
            done[u] = 1'b1;
            if (path_len[u] == Unreach) continue;
            for (int v = 0; v < n; v++) begin
                if (done[v] || edge_weight[u][v] == 0) continue;
                sum = path_len[u] + edge_weight[u][v];
                if (sum >= Unreach) sum = UnreachM1;
                if (path_len[v] > sum) path_len[v] = sum;
            end
        end
        for (int v = 0; v < n; v++) begin
            r.vertex = IdxBits'(v);
            r.distance = DistBits'(path_len[v]);
            r.reachable = (path_len[v] != Unreach);
            r.bad_source = 1'b0;
            r.last = (v + 1 == n);
            expected_paths.push_back(r);
        end
    endfunction

    // Send one command transaction and update the predictor. tvalid stays
    // high after the accept so the next transaction can follow with no gap.
    task automatic send_cmd(cmd_t cmd, logic [3:0] a, logic [3:0] b, logic [15:0] w);
        int gap;
        gap = (gap_level != 0) ? random_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {w, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (cmd)
            CMD_CLEAR: begin
                foreach (edge_weight[i, j]) edge_weight[i][j] = '0;
            end
            CMD_WRITE: begin
                edge_weight[a][b] = w;
                edge_weight[b][a] = w;
            end
            CMD_RUN: predict_paths(a);
            default: ;
        endcase
    endtask

    // Wait until all results are in, then let the core settle before a config write.
    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_paths.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (120) @(posedge aclk);
    endtask

    task automatic set_node_count(logic [4:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        active_nodes = n;
    endtask

    // Result receiver with random stalls, or one long hold-off on request.
    initial begin
        int hold;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (stall_long) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                stall_long = 1'b0;
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            hold = (gap_level != 0 && $urandom_range(0, 3) == 0) ? random_gap() : 0;
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        path_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[3:0], m_tdata[23:4], m_tuser[0], m_tuser[1], m_tlast};
            if (expected_paths.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: %p", got);
            end else begin
                want = expected_paths.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic test_directed();
        gap_level = 0;
        send_cmd(CMD_RUN, 4'd0, 4'd0, 16'd0);        // empty graph
        send_cmd(CMD_WRITE, 4'd0, 4'd1, 16'hFFFF);
        send_cmd(CMD_WRITE, 4'd1, 4'd15, 16'hFFFF);
        send_cmd(CMD_WRITE, 4'd15, 4'd14, 16'd1);
        send_cmd(CMD_WRITE, 4'd3, 4'd3, 16'd7);      // self loop
        send_cmd(CMD_WRITE, 4'd0, 4'd2, 16'd5);
        send_cmd(CMD_WRITE, 4'd2, 4'd3, 16'd5);
        send_cmd(CMD_WRITE, 4'd0, 4'd3, 16'd10);     // tie path
        send_cmd(CMD_NOP, 4'd5, 4'd6, 16'd9);
        send_cmd(CMD_RUN, 4'd0, 4'd0, 16'd0);
        send_cmd(CMD_RUN, 4'd15, 4'd0, 16'd0);
        send_cmd(CMD_WRITE, 4'd0, 4'd2, 16'd0);      // remove an edge
        send_cmd(CMD_RUN, 4'd3, 4'hA, 16'hAAAA);
        set_node_count(5'd1);
        send_cmd(CMD_RUN, 4'd0, 4'd0, 16'd0);
        send_cmd(CMD_RUN, 4'd1, 4'd0, 16'd0);        // bad source
        set_node_count(5'd0);
        send_cmd(CMD_RUN, 4'd0, 4'd0, 16'd0);
        set_node_count(5'd31);                       // saturates to the maximum
        send_cmd(CMD_RUN, 4'd14, 4'd0, 16'd0);
        send_cmd(CMD_CLEAR, 4'hF, 4'hF, 16'hFFFF);
        send_cmd(CMD_RUN, 4'd1, 4'd0, 16'd0);
        set_node_count(5'd16);
    endtask

    // Random graphs: clear, build edges, then one to three runs or no-ops.
    task automatic test_random_graphs(int items);
        int sent;
        int kind;
        sent = 0;
        gap_level = 1;
        while (sent < items) begin
            if ($urandom_range(0, 4) == 0) begin
                set_node_count(5'($urandom_range(0, 4) == 0 ? $urandom_range(0, 31)
                                                            : $urandom_range(2, 16)));
            end
            send_cmd(CMD_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom));
            sent++;
            repeat ($urandom_range(4, 24)) begin
                kind = $urandom_range(0, 9);
                send_cmd(CMD_WRITE, 4'($urandom), 4'($urandom),
                         16'(kind == 0 ? 32'hFFFF - $urandom_range(0, 3) :
                             kind == 1 ? 32'd0 : $urandom_range(1, 300)));
                sent++;
            end
            repeat ($urandom_range(1, 3)) begin
                send_cmd($urandom_range(0, 9) == 0 ? CMD_NOP : CMD_RUN, 4'($urandom),
                         4'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // Long receiver hold-off while runs keep arriving.
    task automatic test_backpressure();
        gap_level = 0;
        stall_long = 1'b1;
        repeat (4) send_cmd(CMD_RUN, 4'($urandom_range(0, 15)), 4'd0, 16'd0);
        gap_level = 1;
    endtask

    initial begin
        int guard;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        stall_long = 1'b0;
        gap_level = 0;
        mismatch_count = 0;
        active_nodes = 5'd16;
        foreach (edge_weight[i, j]) edge_weight[i][j] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_graphs(150);
        test_backpressure();
        test_random_graphs(150);

        s_tvalid <= 1'b0;
        guard = 0;
        while (expected_paths.size() != 0 && guard < 500000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && expected_paths.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
